// ----- sv/gdcd_pkg.sv -----
// gdcd_pkg: types, codes and helpers shared by the gamepad drive command decoder.
// Depends on nothing; used by every module of the block.
package gdcd_pkg;

    // key codes, lowest cleared button bit wins
    localparam logic [4:0] KEY_NONE     = 5'd0;
    localparam logic [4:0] KEY_SELECT   = 5'd1;
    localparam logic [4:0] KEY_L3       = 5'd2;
    localparam logic [4:0] KEY_R3       = 5'd3;
    localparam logic [4:0] KEY_START    = 5'd4;
    localparam logic [4:0] KEY_UP       = 5'd5;
    localparam logic [4:0] KEY_RIGHT    = 5'd6;
    localparam logic [4:0] KEY_DOWN     = 5'd7;
    localparam logic [4:0] KEY_LEFT     = 5'd8;
    localparam logic [4:0] KEY_L2       = 5'd9;
    localparam logic [4:0] KEY_R2       = 5'd10;
    localparam logic [4:0] KEY_L1       = 5'd11;
    localparam logic [4:0] KEY_R1       = 5'd12;
    localparam logic [4:0] KEY_TRIANGLE = 5'd13;
    localparam logic [4:0] KEY_CIRCLE   = 5'd14;
    localparam logic [4:0] KEY_CROSS    = 5'd15;
    localparam logic [4:0] KEY_SQUARE   = 5'd16;

    // configuration register indexes
    localparam logic [2:0] CFG_SPEED_STEP        = 3'd0;
    localparam logic [2:0] CFG_DIAGONAL_OFFSET   = 3'd1;
    localparam logic [2:0] CFG_STICK_EDGE_LOW    = 3'd2;
    localparam logic [2:0] CFG_STICK_EDGE_HIGH   = 3'd3;
    localparam logic [2:0] CFG_STICK_CENTRE_LOW  = 3'd4;
    localparam logic [2:0] CFG_STICK_CENTRE_HIGH = 3'd5;
    localparam logic [2:0] CFG_SERVO_WINDOW_LOW  = 3'd6;
    localparam logic [2:0] CFG_SERVO_WINDOW_HIGH = 3'd7;

    localparam logic [7:0] SPEED_RESET    = 8'd150;
    localparam logic [7:0] SPEED_FLOOR    = 8'd50;
    localparam logic [7:0] SPEED_RECOVER  = 8'd100;
    localparam logic [7:0] DUTY_MAX       = 8'd255;

    localparam logic [7:0] ANGLE_CENTRE = 8'd90;
    localparam logic [7:0] ANGLE_LEFT   = 8'd180;
    localparam logic [7:0] ANGLE_RIGHT  = 8'd0;

    localparam logic [2:0] LED_OFF   = 3'd0;
    localparam logic [2:0] LED_RED   = 3'd1;
    localparam logic [2:0] LED_GREEN = 3'd2;
    localparam logic [2:0] LED_BLUE  = 3'd4;

    // queue between classifier and executor
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    typedef logic [QUEUE_PTR_W-1:0] t_qptr;
    typedef logic [QUEUE_CNT_W-1:0] t_qcnt;
    localparam t_qptr QUEUE_LAST = t_qptr'(QUEUE_DEPTH - 1);
    localparam t_qcnt QUEUE_FULL = t_qcnt'(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        MODE_STOP      = 4'd1,
        MODE_RUN       = 4'd2,
        MODE_BACK      = 4'd3,
        MODE_LEFT      = 4'd4,
        MODE_RIGHT     = 4'd5,
        MODE_UPLEFT    = 4'd8,
        MODE_UPRIGHT   = 4'd9,
        MODE_DOWNLEFT  = 4'd10,
        MODE_DOWNRIGHT = 4'd11
    } t_drive;

    typedef enum logic [1:0] {
        SERVO_CENTRE = 2'd0,
        SERVO_LEFT   = 2'd1,
        SERVO_RIGHT  = 2'd2
    } t_servo;

    typedef enum logic [1:0] {
        DIR_OFF = 2'd0,
        DIR_FWD = 2'd1,
        DIR_REV = 2'd2
    } t_dir;

    typedef struct packed {
        logic [7:0] speed_step;
        logic [7:0] diagonal_offset;
        logic [7:0] stick_edge_low;
        logic [7:0] stick_edge_high;
        logic [7:0] stick_centre_low;
        logic [7:0] stick_centre_high;
        logic [7:0] servo_window_low;
        logic [7:0] servo_window_high;
    } t_cfg;

    // classified frame handed from front to back
    typedef struct packed {
        logic [4:0] key;
        t_drive     stick_mode;
        t_servo     stick_servo;
    } t_cmd;

    typedef struct packed {
        logic       whistle;
        logic [2:0] led_colour;
        logic       led_update;
        logic [7:0] servo_angle;
        logic       servo_move;
        logic [7:0] right_duty;
        t_dir       right_direction;
        logic [7:0] left_duty;
        t_dir       left_direction;
        logic [4:0] key_code;
    } t_res;

    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? DUTY_MAX : s[7:0];
    endfunction

    function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : 8'd0;
    endfunction

endpackage

// ----- sv/gamepad_drive_command_decoder.sv -----
// Gamepad drive command decoder, top level: configuration registers, the
// classifier front, the request queue and the executor back.
// Depends on gdcd_pkg, gdcd_front, gdcd_queue and gdcd_back.
//
// Usage:
//   s_axis carries one polled gamepad frame per beat; m_axis returns exactly
//   one command result per frame, in order. The configuration port writes one
//   8-bit register per cycle with i_cfg_wr_en high; write only while idle.
//   The front decodes the key and classifies both sticks in the accept cycle
//   and pushes into a two-entry queue; the back applies the request to the
//   drive mode, speed and servo state and loads the result register.
//   A frame accepted on s_axis is written into the queue, then popped into the
//   result register. Throughput: one frame per cycle while m_axis_tready is
//   high, set by the single state update in the back.
//   Reset (synchronous, active low) clears the queue and the result valid flag,
//   sets the drive mode to stop, speed to 150, servo to centre and loads the
//   register defaults. When m_axis_tready is low the result holds, the queue
//   fills, and s_axis_tready falls once two frames are waiting.
module gamepad_drive_command_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] buttons_first, [15:8] buttons_second, [23:16] right_x,
    // [31:24] right_y, [39:32] left_x, [47:40] left_y
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] key_code, [6:5] left_direction, [14:7] left_duty,
    // [16:15] right_direction, [24:17] right_duty, [25] servo_move,
    // [33:26] servo_angle, [34] led_update, [37:35] led_colour, [38] whistle
    output logic [39:0] m_axis_tdata
);

    gdcd_pkg::t_cfg r_cfg;
    gdcd_pkg::t_cmd front_cmd, q_cmd;
    gdcd_pkg::t_res res;
    logic q_valid, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_step        <= 8'd50;
            r_cfg.diagonal_offset   <= 8'd30;
            r_cfg.stick_edge_low    <= 8'd5;
            r_cfg.stick_edge_high   <= 8'd230;
            r_cfg.stick_centre_low  <= 8'd80;
            r_cfg.stick_centre_high <= 8'd180;
            r_cfg.servo_window_low  <= 8'd110;
            r_cfg.servo_window_high <= 8'd150;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                gdcd_pkg::CFG_SPEED_STEP:        r_cfg.speed_step        <= i_cfg_data;
                gdcd_pkg::CFG_DIAGONAL_OFFSET:   r_cfg.diagonal_offset   <= i_cfg_data;
                gdcd_pkg::CFG_STICK_EDGE_LOW:    r_cfg.stick_edge_low    <= i_cfg_data;
                gdcd_pkg::CFG_STICK_EDGE_HIGH:   r_cfg.stick_edge_high   <= i_cfg_data;
                gdcd_pkg::CFG_STICK_CENTRE_LOW:  r_cfg.stick_centre_low  <= i_cfg_data;
                gdcd_pkg::CFG_STICK_CENTRE_HIGH: r_cfg.stick_centre_high <= i_cfg_data;
                gdcd_pkg::CFG_SERVO_WINDOW_LOW:  r_cfg.servo_window_low  <= i_cfg_data;
                gdcd_pkg::CFG_SERVO_WINDOW_HIGH: r_cfg.servo_window_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gdcd_front u_front (
        .i_frame (s_axis_tdata),
        .i_cfg   (r_cfg),
        .o_cmd   (front_cmd)
    );

    gdcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_data  (front_cmd),
        .o_ready (s_axis_tready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    gdcd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_data  (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (res)
    );

    assign m_axis_tdata = {1'b0, res};

endmodule

// ----- sv/gdcd_front.sv -----
// gdcd_front: decodes the key code and classifies both sticks of one frame.
// Depends on gdcd_pkg.
module gdcd_front (
    input  logic [47:0]       i_frame,
    input  gdcd_pkg::t_cfg    i_cfg,
    output gdcd_pkg::t_cmd    o_cmd
);

    logic [15:0] keys;
    logic [7:0]  rx, ry, lx, ly;
    logic [4:0]  key;
    logic        xc, yc, sw;
    gdcd_pkg::t_drive mode;
    gdcd_pkg::t_servo servo;

    assign keys = i_frame[15:0];
    assign rx   = i_frame[23:16];
    assign ry   = i_frame[31:24];
    assign lx   = i_frame[39:32];
    assign ly   = i_frame[47:40];

    // priority encoder, bit 0 highest
    always_comb begin
        key = gdcd_pkg::KEY_NONE;
        for (int i = 15; i >= 0; i--) begin
            if (!keys[i]) begin
                key = 5'(i + 1);
            end
        end
    end

    assign xc = (lx > i_cfg.stick_centre_low) && (lx < i_cfg.stick_centre_high);
    assign yc = (ly > i_cfg.stick_centre_low) && (ly < i_cfg.stick_centre_high);
    assign sw = (ry > i_cfg.servo_window_low) && (ry < i_cfg.servo_window_high);

    always_comb begin
        if (ly < i_cfg.stick_edge_low && xc) begin
            mode = gdcd_pkg::MODE_RUN;
        end else if (ly > i_cfg.stick_edge_high && xc) begin
            mode = gdcd_pkg::MODE_BACK;
        end else if (lx < i_cfg.stick_edge_low && yc) begin
            mode = gdcd_pkg::MODE_LEFT;
        end else if (yc && lx > i_cfg.stick_edge_high) begin
            mode = gdcd_pkg::MODE_RIGHT;
        end else if (ly <= i_cfg.stick_centre_low && lx <= i_cfg.stick_centre_low) begin
            mode = gdcd_pkg::MODE_UPLEFT;
        end else if (ly <= i_cfg.stick_centre_low && lx >= i_cfg.stick_centre_high) begin
            mode = gdcd_pkg::MODE_UPRIGHT;
        end else if (lx <= i_cfg.stick_centre_low && ly >= i_cfg.stick_centre_high) begin
            mode = gdcd_pkg::MODE_DOWNLEFT;
        end else if (ly >= i_cfg.stick_centre_high && lx >= i_cfg.stick_centre_high) begin
            mode = gdcd_pkg::MODE_DOWNRIGHT;
        end else begin
            mode = gdcd_pkg::MODE_STOP;
        end
    end

    always_comb begin
        if (rx < i_cfg.stick_edge_low && sw) begin
            servo = gdcd_pkg::SERVO_LEFT;
        end else if (sw && rx > i_cfg.stick_edge_high) begin
            servo = gdcd_pkg::SERVO_RIGHT;
        end else begin
            servo = gdcd_pkg::SERVO_CENTRE;
        end
    end

    assign o_cmd.key         = key;
    assign o_cmd.stick_mode  = mode;
    assign o_cmd.stick_servo = servo;

endmodule

// ----- sv/gdcd_queue.sv -----
// gdcd_queue: short request queue between the classifier and the executor.
// Depends on gdcd_pkg.
module gdcd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gdcd_pkg::t_cmd i_data,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output gdcd_pkg::t_cmd o_data
);

    gdcd_pkg::t_cmd r_mem [gdcd_pkg::QUEUE_DEPTH];
    gdcd_pkg::t_qptr r_wr_ptr, n_wr_ptr;
    gdcd_pkg::t_qptr r_rd_ptr, n_rd_ptr;
    gdcd_pkg::t_qcnt r_count, n_count;
    logic do_push, do_pop;

    assign o_ready = (r_count != gdcd_pkg::QUEUE_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == gdcd_pkg::QUEUE_LAST) ? '0
                     : gdcd_pkg::t_qptr'(r_wr_ptr + 1'b1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == gdcd_pkg::QUEUE_LAST) ? '0
                     : gdcd_pkg::t_qptr'(r_rd_ptr + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_count = gdcd_pkg::t_qcnt'(r_count + 1'b1);
        end else if (do_pop && !do_push) begin
            n_count = gdcd_pkg::t_qcnt'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= gdcd_pkg::QUEUE_FULL)
        else $error("queue count out of range");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_count == gdcd_pkg::t_qcnt'($past(r_count) + 1'b1))
        else $error("queue count missed a push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == gdcd_pkg::QUEUE_FULL) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");

endmodule

// ----- sv/gdcd_back.sv -----
// gdcd_back: executes classified frames against the drive state and holds the
// result register. Depends on gdcd_pkg.
module gdcd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gdcd_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  gdcd_pkg::t_cmd i_q_data,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output gdcd_pkg::t_res o_res
);

    gdcd_pkg::t_drive r_mode, n_mode;
    logic [7:0]       r_speed, n_speed;
    gdcd_pkg::t_servo r_req, n_req;
    gdcd_pkg::t_servo r_app, n_app;
    logic             r_out_valid;
    gdcd_pkg::t_res   r_res, n_res;
    logic [8:0]       sum, diff;
    logic [7:0]       dup, ddown;

    assign o_q_pop = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    always_comb begin
        n_mode  = r_mode;
        n_speed = r_speed;
        n_req   = r_req;
        n_app   = r_app;
        n_res   = '0;
        n_res.key_code        = i_q_data.key;
        n_res.left_direction  = gdcd_pkg::DIR_OFF;
        n_res.right_direction = gdcd_pkg::DIR_OFF;
        sum  = {1'b0, r_speed} + {1'b0, i_cfg.speed_step};
        diff = {1'b0, r_speed} - {1'b0, i_cfg.speed_step};

        unique case (i_q_data.key)
            gdcd_pkg::KEY_NONE,
            gdcd_pkg::KEY_L3:    n_mode = gdcd_pkg::MODE_STOP;
            gdcd_pkg::KEY_R3: begin
                n_res.servo_move  = 1'b1;
                n_res.servo_angle = gdcd_pkg::ANGLE_CENTRE;
                n_app             = gdcd_pkg::SERVO_CENTRE;
            end
            gdcd_pkg::KEY_UP:    n_mode = gdcd_pkg::MODE_RUN;
            gdcd_pkg::KEY_RIGHT: n_mode = gdcd_pkg::MODE_RIGHT;
            gdcd_pkg::KEY_DOWN:  n_mode = gdcd_pkg::MODE_BACK;
            gdcd_pkg::KEY_LEFT:  n_mode = gdcd_pkg::MODE_LEFT;
            gdcd_pkg::KEY_L2:    n_speed = sum[8] ? gdcd_pkg::DUTY_MAX : sum[7:0];
            gdcd_pkg::KEY_R2: begin
                // borrow or below floor falls back to the recovery speed
                n_speed = (diff[8] || diff[7:0] < gdcd_pkg::SPEED_FLOOR)
                        ? gdcd_pkg::SPEED_RECOVER : diff[7:0];
            end
            gdcd_pkg::KEY_L1,
            gdcd_pkg::KEY_R1: begin
                n_mode = i_q_data.stick_mode;
                n_req  = i_q_data.stick_servo;
            end
            gdcd_pkg::KEY_TRIANGLE: begin
                n_res.led_update = 1'b1;
                n_res.led_colour = gdcd_pkg::LED_GREEN;
            end
            gdcd_pkg::KEY_CIRCLE: begin
                n_res.led_update = 1'b1;
                n_res.led_colour = gdcd_pkg::LED_BLUE;
            end
            gdcd_pkg::KEY_CROSS: begin
                n_res.whistle    = 1'b1;
                n_res.led_update = 1'b1;
                n_res.led_colour = gdcd_pkg::LED_OFF;
            end
            gdcd_pkg::KEY_SQUARE: begin
                n_res.led_update = 1'b1;
                n_res.led_colour = gdcd_pkg::LED_RED;
            end
            default: ;
        endcase

        // besides the R3 centre key, the servo is only driven when the request differs from the applied position
        if (n_req != n_app) begin
            n_app            = n_req;
            n_res.servo_move = 1'b1;
            unique case (n_req)
                gdcd_pkg::SERVO_LEFT:  n_res.servo_angle = gdcd_pkg::ANGLE_LEFT;
                gdcd_pkg::SERVO_RIGHT: n_res.servo_angle = gdcd_pkg::ANGLE_RIGHT;
                default:               n_res.servo_angle = gdcd_pkg::ANGLE_CENTRE;
            endcase
        end

        dup   = gdcd_pkg::sat_add(n_speed, i_cfg.diagonal_offset);
        ddown = gdcd_pkg::sat_sub(n_speed, i_cfg.diagonal_offset);

        unique case (n_mode)
            gdcd_pkg::MODE_RUN: begin
                n_res.left_direction  = gdcd_pkg::DIR_FWD;
                n_res.left_duty       = n_speed;
                n_res.right_direction = gdcd_pkg::DIR_FWD;
                n_res.right_duty      = n_speed;
            end
            gdcd_pkg::MODE_BACK: begin
                n_res.left_direction  = gdcd_pkg::DIR_REV;
                n_res.left_duty       = n_speed;
                n_res.right_direction = gdcd_pkg::DIR_REV;
                n_res.right_duty      = n_speed;
            end
            gdcd_pkg::MODE_LEFT: begin
                n_res.right_direction = gdcd_pkg::DIR_FWD;
                n_res.right_duty      = n_speed;
            end
            gdcd_pkg::MODE_RIGHT: begin
                n_res.left_direction  = gdcd_pkg::DIR_FWD;
                n_res.left_duty       = n_speed;
            end
            gdcd_pkg::MODE_UPLEFT: begin
                n_res.left_direction  = gdcd_pkg::DIR_FWD;
                n_res.left_duty       = ddown;
                n_res.right_direction = gdcd_pkg::DIR_FWD;
                n_res.right_duty      = dup;
            end
            gdcd_pkg::MODE_UPRIGHT: begin
                n_res.left_direction  = gdcd_pkg::DIR_FWD;
                n_res.left_duty       = dup;
                n_res.right_direction = gdcd_pkg::DIR_FWD;
                n_res.right_duty      = ddown;
            end
            gdcd_pkg::MODE_DOWNLEFT: begin
                n_res.left_direction  = gdcd_pkg::DIR_REV;
                n_res.left_duty       = ddown;
                n_res.right_direction = gdcd_pkg::DIR_REV;
                n_res.right_duty      = dup;
            end
            gdcd_pkg::MODE_DOWNRIGHT: begin
                n_res.left_direction  = gdcd_pkg::DIR_REV;
                n_res.left_duty       = dup;
                n_res.right_direction = gdcd_pkg::DIR_REV;
                n_res.right_duty      = ddown;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= gdcd_pkg::MODE_STOP;
            r_speed     <= gdcd_pkg::SPEED_RESET;
            r_req       <= gdcd_pkg::SERVO_CENTRE;
            r_app       <= gdcd_pkg::SERVO_CENTRE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_mode  <= n_mode;
                r_speed <= n_speed;
                r_req   <= n_req;
                r_app   <= n_app;
            end
            r_out_valid <= o_q_pop || (r_out_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= n_res;
        end
    end

    a_servo_synced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_app == r_req)
        else $error("servo applied position lags the request");

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_out_valid)
        else $error("executed request produced no result");

    a_speed_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_data.key == gdcd_pkg::KEY_R2) |=> r_speed >= gdcd_pkg::SPEED_FLOOR)
        else $error("speed fell below floor after slow-down key");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for gamepad_drive_command_decoder: stream frames in,
// command results out, scored against a cycle-free model of the key/stick logic.
// Depends on gdcd_pkg and the decoder RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gdcd_pkg::*;

    typedef struct packed {
        logic [7:0] left_y;
        logic [7:0] left_x;
        logic [7:0] right_y;
        logic [7:0] right_x;
        logic [7:0] buttons_second;
        logic [7:0] buttons_first;
    } frame_t;

    typedef struct packed {
        logic       pad;
        logic       whistle;
        logic [2:0] led_colour;
        logic       led_update;
        logic [7:0] servo_angle;
        logic       servo_move;
        logic [7:0] right_duty;
        logic [1:0] right_dir;
        logic [7:0] left_duty;
        logic [1:0] left_dir;
        logic [4:0] key_code;
    } command_t;

    class command_tracker;
        logic [7:0] regs [8];
        t_drive     mode;
        logic [7:0] speed;
        t_servo     servo_req;
        t_servo     servo_applied;
        command_t   pending_cmds [$];
        int         errors;
        int         frames;
        int         stick_frames;
        int         servo_moves;

        function new();
            regs[CFG_SPEED_STEP]        = 8'd50;
            regs[CFG_DIAGONAL_OFFSET]   = 8'd30;
            regs[CFG_STICK_EDGE_LOW]    = 8'd5;
            regs[CFG_STICK_EDGE_HIGH]   = 8'd230;
            regs[CFG_STICK_CENTRE_LOW]  = 8'd80;
            regs[CFG_STICK_CENTRE_HIGH] = 8'd180;
            regs[CFG_SERVO_WINDOW_LOW]  = 8'd110;
            regs[CFG_SERVO_WINDOW_HIGH] = 8'd150;
            mode          = MODE_STOP;
            speed         = SPEED_RESET;
            servo_req     = SERVO_CENTRE;
            servo_applied = SERVO_CENTRE;
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] val);
            regs[idx] = val;
        endfunction

        function int pending();
            return pending_cmds.size();
        endfunction

        function logic [7:0] ceil_add(logic [7:0] a, logic [7:0] b);
            int s;
            s = int'(a) + int'(b);
            return (s > int'(DUTY_MAX)) ? DUTY_MAX : 8'(s);
        endfunction

        function logic [7:0] floor_sub(logic [7:0] a, logic [7:0] b);
            int d;
            d = int'(a) - int'(b);
            return (d < 0) ? 8'd0 : 8'(d);
        endfunction

        // advances the drive/speed/servo state by one frame and returns the command
        function command_t decode_frame(frame_t f);
            command_t   c;
            logic [15:0] btn;
            logic [4:0] key;
            logic [7:0] el, eh, cl, ch, lx, ly, rx, ry, offs;
            logic       xc, yc, sw;
            c    = '0;
            btn  = {f.buttons_second, f.buttons_first};
            el   = regs[CFG_STICK_EDGE_LOW];
            eh   = regs[CFG_STICK_EDGE_HIGH];
            cl   = regs[CFG_STICK_CENTRE_LOW];
            ch   = regs[CFG_STICK_CENTRE_HIGH];
            offs = regs[CFG_DIAGONAL_OFFSET];
            lx = f.left_x;  ly = f.left_y;
            rx = f.right_x; ry = f.right_y;

            key = KEY_NONE;
            for (int i = 15; i >= 0; i--)
                if (!btn[i]) key = 5'(i + 1);

            case (key)
                KEY_NONE, KEY_L3: mode = MODE_STOP;
                KEY_R3: begin
                    c.servo_move  = 1'b1;
                    c.servo_angle = ANGLE_CENTRE;
                    servo_applied = SERVO_CENTRE;
                end
                KEY_UP:    mode = MODE_RUN;
                KEY_RIGHT: mode = MODE_RIGHT;
                KEY_DOWN:  mode = MODE_BACK;
                KEY_LEFT:  mode = MODE_LEFT;
                KEY_L2:    speed = ceil_add(speed, regs[CFG_SPEED_STEP]);
                KEY_R2: begin
                    if (int'(speed) - int'(regs[CFG_SPEED_STEP]) < int'(SPEED_FLOOR))
                        speed = SPEED_RECOVER;
                    else
                        speed = speed - regs[CFG_SPEED_STEP];
                end
                KEY_TRIANGLE: begin c.led_update = 1'b1; c.led_colour = LED_GREEN; end
                KEY_CIRCLE:   begin c.led_update = 1'b1; c.led_colour = LED_BLUE; end
                KEY_CROSS: begin
                    c.whistle    = 1'b1;
                    c.led_update = 1'b1;
                    c.led_colour = LED_OFF;
                end
                KEY_SQUARE: begin c.led_update = 1'b1; c.led_colour = LED_RED; end
                default: ;
            endcase

            if (key == KEY_L1 || key == KEY_R1) begin
                stick_frames++;
                xc = (lx > cl) && (lx < ch);
                yc = (ly > cl) && (ly < ch);
                if (ly < el && xc)              mode = MODE_RUN;
                else if (ly > eh && xc)         mode = MODE_BACK;
                else if (lx < el && yc)         mode = MODE_LEFT;
                else if (yc && lx > eh)         mode = MODE_RIGHT;
                else if (ly <= cl && lx <= cl)  mode = MODE_UPLEFT;
                else if (ly <= cl && lx >= ch)  mode = MODE_UPRIGHT;
                else if (lx <= cl && ly >= ch)  mode = MODE_DOWNLEFT;
                else if (ly >= ch && lx >= ch)  mode = MODE_DOWNRIGHT;
                else                            mode = MODE_STOP;

                sw = (ry > regs[CFG_SERVO_WINDOW_LOW]) && (ry < regs[CFG_SERVO_WINDOW_HIGH]);
                if (rx < el && sw)      servo_req = SERVO_LEFT;
                else if (sw && rx > eh) servo_req = SERVO_RIGHT;
                else                    servo_req = SERVO_CENTRE;
            end

            // servo moves on a centre key or a change; a centre key is overridden by a request that is not centre
            if (servo_req != servo_applied) begin
                servo_applied = servo_req;
                c.servo_move  = 1'b1;
                case (servo_req)
                    SERVO_LEFT:  c.servo_angle = ANGLE_LEFT;
                    SERVO_RIGHT: c.servo_angle = ANGLE_RIGHT;
                    default:     c.servo_angle = ANGLE_CENTRE;
                endcase
            end

            case (mode)
                MODE_RUN: begin
                    c.left_dir = DIR_FWD;  c.left_duty = speed;
                    c.right_dir = DIR_FWD; c.right_duty = speed;
                end
                MODE_BACK: begin
                    c.left_dir = DIR_REV;  c.left_duty = speed;
                    c.right_dir = DIR_REV; c.right_duty = speed;
                end
                MODE_LEFT:  begin c.right_dir = DIR_FWD; c.right_duty = speed; end
                MODE_RIGHT: begin c.left_dir = DIR_FWD;  c.left_duty = speed; end
                MODE_UPLEFT: begin
                    c.left_dir = DIR_FWD;  c.left_duty = floor_sub(speed, offs);
                    c.right_dir = DIR_FWD; c.right_duty = ceil_add(speed, offs);
                end
                MODE_UPRIGHT: begin
                    c.left_dir = DIR_FWD;  c.left_duty = ceil_add(speed, offs);
                    c.right_dir = DIR_FWD; c.right_duty = floor_sub(speed, offs);
                end
                MODE_DOWNLEFT: begin
                    c.left_dir = DIR_REV;  c.left_duty = floor_sub(speed, offs);
                    c.right_dir = DIR_REV; c.right_duty = ceil_add(speed, offs);
                end
                MODE_DOWNRIGHT: begin
                    c.left_dir = DIR_REV;  c.left_duty = ceil_add(speed, offs);
                    c.right_dir = DIR_REV; c.right_duty = floor_sub(speed, offs);
                end
                default: ;
            endcase

            c.key_code = key;
            servo_moves += c.servo_move;
            return c;
        endfunction

        function void accept_frame(frame_t f);
            frames++;
            pending_cmds.push_back(decode_frame(f));
        endfunction

        task report(string what);
            errors++;
            // keep the log bounded on a badly broken block
            if (errors <= 40)
                $display("mismatch at %0t ns: %s", $time, what);
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("%s got %0h, expected %0h", name, got, want));
        endtask

        task compare_command(logic [39:0] data);
            command_t got;
            command_t want;
            got = command_t'(data);
            if (pending_cmds.size() == 0) begin
                report($sformatf("result %h with no request pending", data));
                return;
            end
            want = pending_cmds.pop_front();
            check_field("key_code", got.key_code, want.key_code);
            check_field("left_direction", got.left_dir, want.left_dir);
            check_field("left_duty", got.left_duty, want.left_duty);
            check_field("right_direction", got.right_dir, want.right_dir);
            check_field("right_duty", got.right_duty, want.right_duty);
            check_field("servo_move", got.servo_move, want.servo_move);
            check_field("servo_angle", got.servo_angle, want.servo_angle);
            check_field("led_update", got.led_update, want.led_update);
            check_field("led_colour", got.led_colour, want.led_colour);
            check_field("whistle", got.whistle, want.whistle);
            check_field("padding", got.pad, want.pad);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    command_tracker sb;
    bit calm = 1'b0;    // no idling on either side
    bit gappy = 1'b1;   // sender may leave gaps in this stretch
    int settings = 1;

    gamepad_drive_command_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver back-pressure
    initial begin
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.compare_command(m_axis_tdata);

    function automatic frame_t keyed(int key, logic [7:0] lx, logic [7:0] ly,
                                     logic [7:0] rx, logic [7:0] ry);
        frame_t f;
        logic [15:0] btn;
        btn = (key == KEY_NONE) ? 16'hFFFF : ~(16'd1 << (key - 1));
        f.buttons_first  = btn[7:0];
        f.buttons_second = btn[15:8];
        f.left_x  = lx;
        f.left_y  = ly;
        f.right_x = rx;
        f.right_y = ry;
        return f;
    endfunction

    // stick values cluster around the current thresholds, plus the rails and uniform picks
    function automatic logic [7:0] pick_axis();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (sel == 0)      v = 0;
        else if (sel == 1) v = 255;
        else if (sel < 5)  v = $urandom_range(0, 255);
        else begin
            v = int'(sb.regs[$urandom_range(CFG_STICK_EDGE_LOW, CFG_SERVO_WINDOW_HIGH)])
                + $urandom_range(0, 2) - 1;
            if (v < 0)   v = 0;
            if (v > 255) v = 255;
        end
        return 8'(v);
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        logic [15:0] btn;
        int sel;
        int key;
        sel = $urandom_range(0, 19);
        btn = 16'($urandom);
        if (sel != 0) begin
            if (sel < 8) key = $urandom_range(0, 1) ? KEY_L1 : KEY_R1;
            else         key = $urandom_range(KEY_NONE, KEY_SQUARE);
            if (key == KEY_NONE) begin
                btn = 16'hFFFF;
            end else begin
                btn = btn | ((16'd1 << (key - 1)) - 16'd1);
                btn[key - 1] = 1'b0;
            end
        end
        f.buttons_first  = btn[7:0];
        f.buttons_second = btn[15:8];
        f.left_x  = pick_axis();
        f.left_y  = pick_axis();
        f.right_x = pick_axis();
        f.right_y = pick_axis();
        return f;
    endfunction

    task automatic send_frame(frame_t f);
        int gap;
        gap = (!calm && gappy && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.accept_frame(f);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic load_settings(int phase);
        logic [7:0] v [8];
        int el, cl, ch;
        case (phase)
            1: foreach (v[i]) v[i] = 8'h00;
            2: foreach (v[i]) v[i] = 8'hFF;
            3: begin
                // well-ordered windows so every drive mode is reachable
                el = $urandom_range(1, 60);
                cl = $urandom_range(el + 1, 120);
                ch = $urandom_range(cl + 2, 200);
                v[CFG_SPEED_STEP]        = 8'($urandom_range(0, 255));
                v[CFG_DIAGONAL_OFFSET]   = 8'($urandom_range(0, 255));
                v[CFG_STICK_EDGE_LOW]    = 8'(el);
                v[CFG_STICK_CENTRE_LOW]  = 8'(cl);
                v[CFG_STICK_CENTRE_HIGH] = 8'(ch);
                v[CFG_STICK_EDGE_HIGH]   = 8'($urandom_range(ch + 1, 254));
                v[CFG_SERVO_WINDOW_LOW]  = 8'($urandom_range(60, 127));
                v[CFG_SERVO_WINDOW_HIGH] = 8'($urandom_range(v[CFG_SERVO_WINDOW_LOW] + 2, 200));
            end
            4: foreach (v[i]) v[i] = 8'($urandom);
            default: begin
                v[CFG_SPEED_STEP]        = 8'd50;
                v[CFG_DIAGONAL_OFFSET]   = 8'd30;
                v[CFG_STICK_EDGE_LOW]    = 8'd5;
                v[CFG_STICK_EDGE_HIGH]   = 8'd230;
                v[CFG_STICK_CENTRE_LOW]  = 8'd80;
                v[CFG_STICK_CENTRE_HIGH] = 8'd180;
                v[CFG_SERVO_WINDOW_LOW]  = 8'd110;
                v[CFG_SERVO_WINDOW_HIGH] = 8'd150;
            end
        endcase
        foreach (v[i]) write_reg(3'(i), v[i]);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        settings++;
    endtask

    initial begin
        frame_t f;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every key once under reset settings, then stick and speed corners
        send_frame(keyed(KEY_NONE, 8'h00, 8'h00, 8'h00, 8'h00));
        for (int k = KEY_SELECT; k <= KEY_SQUARE; k++) begin
            if (k == KEY_L1)      send_frame(keyed(k, 8'd128, 8'd0, 8'd0, 8'd128));
            else if (k == KEY_R1) send_frame(keyed(k, 8'd255, 8'd255, 8'd255, 8'd128));
            else                  send_frame(keyed(k, {8{k[0]}}, {8{k[0]}}, 8'hFF, 8'h00));
        end
        // centre key while the stick still asks for right: two servo moves
        send_frame(keyed(KEY_R3, 8'd0, 8'd0, 8'd0, 8'd0));
        send_frame(keyed(KEY_L1, 8'd0, 8'd128, 8'd128, 8'd128));
        send_frame(keyed(KEY_R1, 8'd0, 8'd0, 8'd0, 8'd0));
        send_frame(keyed(KEY_L1, 8'd255, 8'd0, 8'd255, 8'd255));
        f = '0;
        send_frame(f);
        // speed down past the floor falls back to the recovery speed
        repeat (3) send_frame(keyed(KEY_R2, 8'd0, 8'd0, 8'd0, 8'd0));
        drain();

        for (int p = 1; p <= 5; p++) begin
            load_settings(p);
            for (int n = 0; n < 240; n++) begin
                if (n % 40 == 0) gappy = ($urandom_range(0, 2) != 0);
                if (p == 5 && n >= 140) calm = 1'b1;
                send_frame(random_frame());
            end
            drain();
        end
        repeat (8) @(posedge i_clk);

        $display("covered %0d frames over %0d register settings, all keys and stick windows",
                 sb.frames, settings);
        $display("%0d stick-steered frames, %0d servo moves, %0d mismatches",
                 sb.stick_frames, sb.servo_moves, sb.errors);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
